// ===== rtl/core/fcs_pkg.sv =====
`default_nettype none

package fcs_pkg;

  // Line store geometry.
  localparam int MAX_WIDTH = 2048;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int USE_W     = ADDR_W + 1;

  // Field widths.
  localparam int HEAT_W    = 8;
  localparam int CFG_W     = 12;
  localparam int SUM_W     = HEAT_W + 2;

  localparam int MIN_WIDTH = 3;
  localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = CFG_W'(640);

  typedef logic [HEAT_W-1:0] heat_t;
  typedef logic [CFG_W-1:0]  cfg_width_t;
  typedef logic [ADDR_W-1:0] col_t;
  typedef logic [USE_W-1:0]  use_width_t;
  typedef logic [SUM_W-1:0]  sum_t;

  // Control that travels with a pixel from acceptance to the stencil stage.
  typedef struct packed {
    logic col_zero;
    logic first_row;
    logic right_ok;
    logic last;
  } fcs_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/fcs_if.sv =====
`default_nettype none

// Pixel input channel.
interface fcs_pix_in_if import fcs_pkg::*;;
  logic  valid;
  logic  ready;
  heat_t heat_in;
  logic  frame_start;

  modport source (output valid, output heat_in, output frame_start, input ready);
  modport sink (input valid, input heat_in, input frame_start, output ready);
endinterface

// Pixel output channel.
interface fcs_pix_out_if import fcs_pkg::*;;
  logic  valid;
  logic  ready;
  heat_t heat_out;
  logic  row_end;

  modport source (output valid, output heat_out, output row_end, input ready);
  modport sink (input valid, input heat_out, input row_end, output ready);
endinterface

// Row width write channel.
interface fcs_cfg_if import fcs_pkg::*;;
  logic       valid;
  logic       ready;
  cfg_width_t row_width;

  modport source (output valid, output row_width, input ready);
  modport sink (input valid, input row_width, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fcs_line_ram.sv =====
`default_nettype none

module fcs_line_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two registered read ports; a read at the written address returns the old word.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fire_cooling_stencil_unit.sv =====
`default_nettype none

// Fire cooling stencil. Takes one heat pixel per clock, rows bottom-up and
// columns left to right, and returns one cooled pixel per clock while pix_out
// is not stalled: (p + bl + b + br - 1) >> 2, or 0 when the sum is zero, with
// neighbors outside the frame read as zero. A pixel passes through the stencil
// stage register and then the output register. The line store is a 2048 x 8
// memory with one write port and two read ports that is read at the pixel's
// column and the next column and written at the pixel's column in the cycle the
// pixel is accepted. The line store needs no clearing after reset: the first row
// of every frame reads the row below as zero. Write row_width only while no
// pixel is in flight; values below 3 act as 3, above 2048 as 2048.
module fire_cooling_stencil_unit import fcs_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  fcs_pix_in_if.sink  pix_in,
  fcs_pix_out_if.source pix_out,
  fcs_cfg_if.sink     cfg
);

  // Configuration and position state.
  cfg_width_t row_width;
  col_t       column_count;
  logic       first_row_flag;

  // Acceptance stage signals.
  use_width_t w_use;
  logic       in_fire;
  logic       start;
  logic       cnt_wrap;
  col_t       col;
  col_t       col_right;
  logic       first_eff;
  logic       last;

  // Stencil stage.
  logic      s1_valid;
  heat_t     s1_heat;
  fcs_ctrl_t s1_ctrl;
  logic      s1_adv;
  heat_t     rd_mid;
  heat_t     rd_right;
  heat_t     win_mid;
  heat_t     left_eff;
  heat_t     mid_eff;
  heat_t     right_eff;
  sum_t      sum;
  sum_t      sum_dec;

  // Output register.
  logic  out_valid;
  heat_t out_heat;
  logic  out_row_end;

  // Width in use, clamped to the supported range.
  always_comb begin
    if (32'(row_width) < MIN_WIDTH) begin
      w_use = USE_W'(MIN_WIDTH);
    end else if (32'(row_width) > MAX_WIDTH) begin
      w_use = USE_W'(MAX_WIDTH);
    end else begin
      w_use = USE_W'(32'(row_width));
    end
  end

  // Column of the pixel at the input and its row flags.
  always_comb begin
    in_fire   = pix_in.valid && pix_in.ready;
    start     = pix_in.frame_start;
    cnt_wrap  = {1'b0, column_count} >= w_use;
    col       = (start || cnt_wrap) ? '0 : column_count;
    col_right = col + col_t'(1);
    first_eff = start || first_row_flag;
    last      = {1'b0, col} == (w_use - use_width_t'(1));
  end

  assign s1_adv       = s1_valid && (!out_valid || pix_out.ready);
  assign pix_in.ready = !s1_valid || s1_adv;
  assign cfg.ready    = 1'b1;

  // Row width register.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RESET;
    end else if (cfg.valid) begin
      row_width <= cfg.row_width;
    end
  end

  // Column counter and bottom-row flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count   <= '0;
      first_row_flag <= 1'b1;
    end else if (in_fire) begin
      column_count   <= last ? '0 : col + col_t'(1);
      first_row_flag <= last ? 1'b0 : first_eff;
    end
  end

  // Line store: old row-below pixels at this column and the next.
  fcs_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (HEAT_W)
  ) u_line_ram (
    .clk     (clk),
    .we      (in_fire),
    .waddr   (col),
    .wdata   (pix_in.heat_in),
    .re      (in_fire),
    .raddr_a (col),
    .raddr_b (col_right),
    .rdata_a (rd_mid),
    .rdata_b (rd_right)
  );

  // Stencil stage register, loaded alongside the memory read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_heat           <= pix_in.heat_in;
      s1_ctrl.col_zero  <= col == '0;
      s1_ctrl.first_row <= first_eff;
      s1_ctrl.right_ok  <= !last;
      s1_ctrl.last      <= last;
    end
  end

  // Neighbor masking and the cooled sum.
  always_comb begin
    mid_eff   = s1_ctrl.first_row ? '0 : rd_mid;
    right_eff = (s1_ctrl.first_row || !s1_ctrl.right_ok) ? '0 : rd_right;
    left_eff  = (s1_ctrl.first_row || s1_ctrl.col_zero) ? '0 : win_mid;
    sum       = sum_t'(s1_heat) + sum_t'(left_eff) + sum_t'(mid_eff) + sum_t'(right_eff);
    sum_dec   = (sum == '0) ? '0 : sum - sum_t'(1);
  end

  // The middle neighbor of one pixel is the left neighbor of the next.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_mid <= '0;
    end else if (s1_adv) begin
      win_mid <= mid_eff;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_heat    <= heat_t'(sum_dec >> 2);
      out_row_end <= s1_ctrl.last;
    end
  end

  assign pix_out.valid    = out_valid;
  assign pix_out.heat_out = out_heat;
  assign pix_out.row_end  = out_row_end;

  // An accepted beat always lands in the stencil stage.
  a_fire_fills_s1: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> s1_valid)
    else $error("accepted pixel did not reach the stencil stage");

  // Read data must hold while the stencil stage is stalled.
  a_rd_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(rd_mid) && $stable(rd_right)))
    else $error("line store read data changed under a stalled pixel");

  // The last pixel of a row restarts the column count on the next row.
  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    (in_fire && last) |=> (column_count == '0 && !first_row_flag))
    else $error("column count did not wrap at row end");

  // A frame start keeps the row below masked until the row ends.
  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    (in_fire && start && !last) |=> first_row_flag)
    else $error("frame start did not mark the bottom row");

  // The cooled value can never reach full scale.
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_heat != '1))
    else $error("cooled heat out of range");

endmodule

`default_nettype wire
